>>> rtl/core/srrw_pkg.sv
`timescale 1ns / 1ps
package srrw_pkg;

   localparam int OFFSET_W    = 32;
   localparam int KIND_W      = 2;
   localparam int WIN_CFG_W   = 5;
   localparam int SEG_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int NAK_OFF_W   = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_SIZE = 2'd1;

   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NAK     = 2'd2;

   localparam logic [WIN_CFG_W-1:0] WIN_RESET = 5'd16;
   localparam logic [SEG_W-1:0]     SEG_RESET = 16'd1024;

   typedef struct packed {
      logic load;
      logic search_step;
      logic mark_slot;
      logic set_nak;
      logic emit_nak;
      logic mark_head;
      logic drain_step;
      logic emit_ack;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic search_last;
      logic slot_zero;
      logic nak_pending;
      logic drain_more;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/core/srrw_req_if.sv
`timescale 1ns / 1ps
interface srrw_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seq_offset;

   modport source (output valid, output seq_offset, input ready);
   modport sink   (input valid, input seq_offset, output ready);
endinterface

>>> rtl/core/srrw_rsp_if.sv
`timescale 1ns / 1ps
interface srrw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] offset;
   logic        last;

   modport source (output valid, output result_kind, output offset, output last,
                   input ready);
   modport sink   (input valid, input result_kind, input offset, input last,
                   output ready);
endinterface

>>> rtl/core/srrw_ctrl.sv
`timescale 1ns / 1ps
module srrw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srrw_pkg::sts_type sts,
   output srrw_pkg::cmd_type cmd
);
   import srrw_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_NAK    = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_ACK    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (sts.hit) begin
               if (sts.slot_zero) begin
                  cmd.mark_head = 1'b1;
                  state_in      = S_DRAIN;
               end else if (!sts.nak_pending) begin
                  cmd.mark_slot = 1'b1;
                  cmd.set_nak   = 1'b1;
                  state_in      = S_NAK;
               end else begin
                  // out of order with a NAK already outstanding: mark only
                  cmd.mark_slot = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (sts.search_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_NAK: begin
            if (sts.out_free) begin
               cmd.emit_nak = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (!sts.drain_more) begin
               state_in = S_ACK;
            end else if (sts.out_free) begin
               cmd.drain_step = 1'b1;
            end
         end
         S_ACK: begin
            if (sts.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/srrw_dp.sv
`timescale 1ns / 1ps
module srrw_dp #(
   parameter int WIN_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [srrw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srrw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [srrw_pkg::OFFSET_W-1:0]       req_seq_offset,
   input  srrw_pkg::cmd_type                   cmd,
   output srrw_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srrw_pkg::KIND_W-1:0]         rsp_result_kind,
   output logic [srrw_pkg::OFFSET_W-1:0]       rsp_offset,
   output logic                                rsp_last
);
   import srrw_pkg::*;

   localparam int HW = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
   localparam int CW = $clog2(WIN_MAX + 1);
   localparam int SW = CW + 1;
   localparam int AW = SEG_W + CW;

   logic [WIN_CFG_W-1:0] win_cfg_ff;
   logic [SEG_W-1:0]     seg_cfg_ff;
   logic [OFFSET_W-1:0]  expected_ff;
   logic                 nak_ff;
   logic [WIN_MAX-1:0]   marks_ff;
   logic [HW-1:0]        head_ff;
   logic [OFFSET_W-1:0]  dist_ff;
   logic [AW-1:0]        acc_ff;
   logic [CW-1:0]        k_ff;
   logic [OFFSET_W-1:0]  prev_ff;
   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    rsp_kind_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;
   logic                 rsp_last_ff;

   logic [SEG_W-1:0] eff_seg;
   logic [CW-1:0]    eff_win;
   logic [SW-1:0]    slot_sum;
   logic [HW-1:0]    slot;
   logic [HW-1:0]    head_next;
   logic             out_free;

   always_comb begin
      eff_seg = (seg_cfg_ff == '0) ? SEG_W'(1) : seg_cfg_ff;
      if (win_cfg_ff == '0) begin
         eff_win = CW'(1);
      end else if (32'(win_cfg_ff) > 32'(WIN_MAX)) begin
         eff_win = CW'(WIN_MAX);
      end else begin
         eff_win = CW'(win_cfg_ff);
      end
   end

   // ring slot of the matched segment, head + k folded back once
   always_comb begin
      slot_sum = SW'(head_ff) + SW'(k_ff);
      if (slot_sum >= SW'(WIN_MAX)) begin
         slot = HW'(slot_sum - SW'(WIN_MAX));
      end else begin
         slot = HW'(slot_sum);
      end
      head_next = (head_ff == HW'(WIN_MAX - 1)) ? '0 : head_ff + HW'(1);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts             = '0;
      sts.hit         = (OFFSET_W'(acc_ff) == dist_ff);
      sts.search_last = (k_ff == eff_win - CW'(1));
      sts.slot_zero   = (k_ff == '0);
      sts.nak_pending = nak_ff;
      sts.drain_more  = (k_ff < eff_win) && marks_ff[head_ff];
      sts.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= WIN_RESET;
         seg_cfg_ff <= SEG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_SIZE:  win_cfg_ff <= csr_wdata[WIN_CFG_W-1:0];
            REG_SEGMENT_SIZE: seg_cfg_ff <= csr_wdata[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         nak_ff      <= 1'b0;
         marks_ff    <= '0;
         head_ff     <= '0;
      end else begin
         if (cmd.set_nak) begin
            nak_ff <= 1'b1;
         end else if (cmd.emit_ack) begin
            nak_ff <= 1'b0;
         end
         if (cmd.mark_slot) begin
            marks_ff[slot] <= 1'b1;
         end else if (cmd.mark_head) begin
            marks_ff[head_ff] <= 1'b1;
         end else if (cmd.drain_step) begin
            marks_ff[head_ff] <= 1'b0;
         end
         if (cmd.drain_step) begin
            expected_ff <= expected_ff + OFFSET_W'(eff_seg);
            head_ff     <= head_next;
         end
      end
   end

   // search: acc walks k * segment_size until it meets the distance
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dist_ff <= req_seq_offset - expected_ff;
         acc_ff  <= '0;
         k_ff    <= '0;
      end else if (cmd.search_step) begin
         acc_ff <= acc_ff + AW'(eff_seg);
         k_ff   <= k_ff + CW'(1);
      end else if (cmd.drain_step) begin
         k_ff <= k_ff + CW'(1);
      end
      if (cmd.drain_step) begin
         prev_ff <= expected_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_nak || cmd.drain_step || cmd.emit_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_nak) begin
         rsp_kind_ff   <= KIND_NAK;
         rsp_offset_ff <= {{(OFFSET_W - NAK_OFF_W){1'b0}}, expected_ff[NAK_OFF_W-1:0]};
         rsp_last_ff   <= 1'b1;
      end else if (cmd.drain_step) begin
         rsp_kind_ff   <= KIND_DELIVER;
         rsp_offset_ff <= expected_ff;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_ack) begin
         rsp_kind_ff   <= KIND_ACK;
         rsp_offset_ff <= prev_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> rtl/core/selective_repeat_receiver_window.sv
`timescale 1ns / 1ps
// Receiver window control for a selective-repeat link with NAKs.
// req_chan carries one segment offset per transfer; rsp_chan returns
// deliver, cumulative ACK and NAK results, with last set on the final
// result caused by a segment. csr_we/csr_index/csr_wdata write
// window_size (index 0) and segment_size (index 1); write only when idle.
// Steps: the block registers the segment, then the slot search steps one
// window slot per cycle and discards a segment that matches no slot. An
// out-of-order segment with no NAK pending then gives a NAK. An in-order
// segment drains one deliver per cycle while rsp_chan takes them, stops
// at the gap, then gives one ACK.
// req_chan.ready is high only while the block is idle; one segment is in
// work at a time. Results sit in an output register; a stalled rsp_chan
// holds the drain in place, nothing is dropped.
// Reset (synchronous): expected offset 0, no NAK pending, all marks
// cleared, window_size 16, segment_size 1024.
module selective_repeat_receiver_window #(
   parameter int WIN_MAX = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   srrw_req_if.sink                         req_chan,
   srrw_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [srrw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srrw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srrw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srrw_dp #(
      .WIN_MAX (WIN_MAX)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_seq_offset  (req_chan.seq_offset),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_result_kind (rsp_chan.result_kind),
      .rsp_offset      (rsp_chan.offset),
      .rsp_last        (rsp_chan.last)
   );

endmodule

>>> verif/selective_repeat_receiver_window_tb.sv
`timescale 1ns / 1ps
module selective_repeat_receiver_window_tb;
   import srrw_pkg::*;

   localparam int WIN_MAX     = 16;
   localparam int IDLE_PCT    = 18;
   localparam int NOISE_PCT   = 15;
   localparam int DUP_PCT     = 8;
   localparam int PHASE_ITEMS = 24;
   localparam int ITEM_GOAL   = 160;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   // index that maps to no register
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] offset;
      logic                last;
   } rsp_item_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   srrw_req_if req_if ();
   srrw_rsp_if rsp_if ();

   selective_repeat_receiver_window #(
      .WIN_MAX (WIN_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [WIN_CFG_W-1:0] win_cfg = WIN_RESET;
   logic [SEG_W-1:0]     seg_cfg = SEG_RESET;

   // receive window state as the block should hold it
   logic [OFFSET_W-1:0] exp_off   = '0;
   bit                  nak_pend  = 1'b0;
   bit [WIN_MAX-1:0]    marks     = '0;
   logic [3:0]          ring_head = '0;

   logic [OFFSET_W-1:0] segment_q[$];
   rsp_item_type        due_results[$];

   logic [OFFSET_W-1:0] gen_next = '0;
   int                  sent_ok = 0;
   int                  errors = 0;
   int                  cycle_count = 0;
   bit                  calm = 1'b0;
   int                  stall_asks = 0;
   int                  stall_seen = 0;
   int                  hold_left = 0;

   function automatic logic [31:0] win_eff();
      if (win_cfg == 0) return 1;
      if (win_cfg > WIN_MAX) return WIN_MAX;
      return win_cfg;
   endfunction

   function automatic logic [31:0] seg_eff();
      return (seg_cfg == 0) ? 32'd1 : 32'(seg_cfg);
   endfunction

   // For an aligned segment inside the window, marks its slot and queues the NAK or the in-order drain it causes.
   task automatic window_advance(input logic [OFFSET_W-1:0] seq);
      logic [31:0] s;
      logic [31:0] w;
      logic [31:0] span;
      logic [31:0] k;
      logic [31:0] prev;
      logic [3:0]  slot;
      int          steps;
      s = seg_eff();
      w = win_eff();
      span = seq - exp_off;
      if (span % s != 0) return;
      k = span / s;
      if (k >= w) return;
      slot = ring_head + k[3:0];
      if (k != 0) begin
         // only the first out-of-order segment asks for a repair
         if (!nak_pend) begin
            nak_pend = 1'b1;
            due_results.push_back({KIND_NAK, 8'h00, exp_off[NAK_OFF_W-1:0], 1'b1});
         end
         marks[slot] = 1'b1;
         return;
      end
      marks[slot] = 1'b1;
      prev = exp_off;
      steps = 0;
      while (steps < w && marks[ring_head]) begin
         due_results.push_back({KIND_DELIVER, exp_off, 1'b0});
         marks[ring_head] = 1'b0;
         prev = exp_off;
         exp_off = exp_off + s;
         ring_head = ring_head + 4'd1;
         steps++;
      end
      nak_pend = 1'b0;
      due_results.push_back({KIND_ACK, prev, 1'b1});
   endtask

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) window_advance(req_if.seq_offset);
         if (!req_if.valid || req_if.ready) begin
            if (segment_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid      <= 1'b1;
               req_if.seq_offset <= segment_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (stall_seen != stall_asks) begin
         stall_seen   <= stall_asks;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d offset %h last %b",
                     $time, rsp_if.result_kind, rsp_if.offset, rsp_if.last);
         end else begin
            want = due_results.pop_front();
            if (rsp_if.result_kind !== want.kind) begin
               errors++;
               $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                        $time, want.kind, rsp_if.result_kind);
            end
            if (rsp_if.offset !== want.offset) begin
               errors++;
               $display("%0t: offset mismatch, expected %h, actual %h",
                        $time, want.offset, rsp_if.offset);
            end
            if (rsp_if.last !== want.last) begin
               errors++;
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_if.last);
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == REG_WINDOW_SIZE) win_cfg = data[WIN_CFG_W-1:0];
      else if (idx == REG_SEGMENT_SIZE) seg_cfg = data[SEG_W-1:0];
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (segment_q.size() != 0 || req_if.valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Up to one window's worth of segments in shuffled order, with some noise and duplicates mixed in.
   task automatic queue_round(input int n);
      int          order[WIN_MAX];
      int          j;
      int          t;
      int          pick;
      logic [31:0] s;
      logic [31:0] w;
      logic [31:0] off;
      logic [31:0] noise;
      s = seg_eff();
      w = win_eff();
      for (j = 0; j < n; j++) order[j] = j;
      for (j = n - 1; j > 0; j--) begin
         pick = $urandom_range(0, j);
         t = order[j];
         order[j] = order[pick];
         order[pick] = t;
      end
      for (j = 0; j < n; j++) begin
         off = gen_next + order[j] * s;
         if ($urandom_range(99) < NOISE_PCT) begin
            case ($urandom_range(3))
               0: noise = (s > 1) ? off + $urandom_range(1, s - 1) : $urandom;
               1: noise = gen_next + (n + w + $urandom_range(0, 40)) * s;
               2: noise = gen_next - $urandom_range(1, 8) * s;
               default: noise = $urandom;
            endcase
            segment_q.push_back(noise);
         end
         segment_q.push_back(off);
         sent_ok++;
         if ($urandom_range(99) < DUP_PCT) segment_q.push_back(off);
      end
      gen_next = gen_next + n * s;
   endtask

   task automatic run_phase(input logic [WIN_CFG_W-1:0] win_w, input logic [SEG_W-1:0] seg_w,
                            input bit stall, input bit quiet);
      logic [CSR_DATA_W-WIN_CFG_W-1:0] junk;
      int                              start;
      junk = $urandom;
      csr_write(REG_WINDOW_SIZE, {junk, win_w});
      csr_write(REG_SPARE, CSR_DATA_W'($urandom));
      csr_write(REG_SEGMENT_SIZE, seg_w);
      @(posedge clock);
      csr_we <= 1'b0;
      calm = quiet;
      if (stall) stall_asks++;
      gen_next = exp_off;
      start = sent_ok;
      while (sent_ok - start < PHASE_ITEMS) queue_round($urandom_range(1, win_eff()));
      wait_drained();
      calm = 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] s;
      int          k;
      logic [SEG_W-1:0] seg_pick;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = REG_WINDOW_SIZE;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.seq_offset = '0;
      rsp_if.ready      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, at reset settings: window 16, step 1024
      s = seg_eff();
      segment_q.push_back(0);            // in order
      segment_q.push_back(3 * s);        // first gap: NAK
      segment_q.push_back(5 * s);        // marked quietly
      segment_q.push_back(5 * s);        // duplicate while NAK pending
      segment_q.push_back(s + 1);        // misaligned
      segment_q.push_back(17 * s);       // beyond the window
      segment_q.push_back(2 * s);
      segment_q.push_back(s);            // drain stops at the gap
      segment_q.push_back(5 * s);        // already marked, still NAKs
      segment_q.push_back(4 * s);
      segment_q.push_back(32'hFFFF_FFFF);
      // fill the whole window ahead, then the head: longest drain
      for (k = 15; k >= 1; k--) segment_q.push_back(6 * s + k * s);
      segment_q.push_back(6 * s);
      wait_drained();

      run_phase(5'd1, 16'd1, 1'b0, 1'b0);
      run_phase(5'd16, 16'hFFFF, 1'b1, 1'b0);
      run_phase(5'd0, 16'd0, 1'b0, 1'b0);
      run_phase(5'd31, 16'd3, 1'b0, 1'b1);
      while (sent_ok < ITEM_GOAL) begin
         seg_pick = ($urandom_range(3) == 0) ? SEG_W'($urandom_range(1, 65535))
                                             : SEG_W'($urandom_range(1, 2048));
         run_phase(WIN_CFG_W'($urandom_range(1, WIN_MAX)), seg_pick, 1'b0, 1'b0);
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/srrw_pkg.sv
rtl/core/srrw_req_if.sv
rtl/core/srrw_rsp_if.sv
rtl/core/srrw_ctrl.sv
rtl/core/srrw_dp.sv
rtl/core/selective_repeat_receiver_window.sv
verif/selective_repeat_receiver_window_tb.sv
